// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the touch key encoder checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication that is also checked during reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// ===== rtl/tkre_pkg.sv =====
// ---------------------------------------------------------------------------
// tkre_pkg
// Types, codes and helpers shared by the touch key repeat encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package tkre_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned DELAY_W = 24;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned CLICK_W = 2;
  localparam int unsigned KEY_W   = 2;

  // Packed stream widths
  localparam int unsigned IN_DATA_W  = 56;  // 51 bits of fields, padded to bytes
  localparam int unsigned OUT_DATA_W = 24;  // 17 bits of fields, padded to bytes

  // Item kinds (tuser)
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Key numbers
  localparam logic [KEY_W-1:0] KEY_LEFT    = 2'd0;
  localparam logic [KEY_W-1:0] KEY_SELECT  = 2'd1;
  localparam logic [KEY_W-1:0] KEY_RIGHT   = 2'd2;
  localparam logic [KEY_W-1:0] KEY_INVALID = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_ROTATED_270  = 2'd0;
  localparam logic [1:0] REG_INIT_DELAY   = 2'd1;
  localparam logic [1:0] REG_REPEAT_INTVL = 2'd2;
  localparam logic [1:0] REG_MAX_CLICKS   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [DELAY_W-1:0] INIT_DELAY_RST   = 24'd400000;
  localparam logic [DELAY_W-1:0] REPEAT_INTVL_RST = 24'd150000;
  localparam logic [CLICK_W-1:0] MAX_CLICKS_RST   = 2'd2;

  // Saturation limits of the step count
  localparam logic signed [STEP_W-1:0] STEP_MAX = 16'sh7FFF;
  localparam logic signed [STEP_W-1:0] STEP_MIN = 16'sh8000;

  // One input item after unpacking
  typedef struct packed {
    logic              op;
    logic [KEY_W-1:0]  key_number;
    logic              key_down;
    logic [TIME_W-1:0] time_us;
  } item_t;

  // Command to one repeat lane (left or right key)
  typedef struct packed {
    logic              press;
    logic              release_key;
    logic              poll;
    logic [TIME_W-1:0] now;
  } lane_cmd_t;

  // Command to the select click queue
  typedef struct packed {
    logic press;
    logic release_key;
    logic poll;
  } click_cmd_t;

  // One saturating step up or down
  function automatic logic signed [STEP_W-1:0] sat_step(
    input logic signed [STEP_W-1:0] acc,
    input logic                     up
  );
    logic signed [STEP_W-1:0] res;
    if (up) begin
      res = (acc == STEP_MAX) ? acc : acc + 16'sd1;
    end else begin
      res = (acc == STEP_MIN) ? acc : acc - 16'sd1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/touch_key_repeat_encoder.sv =====
// ---------------------------------------------------------------------------
// touch_key_repeat_encoder
// Three touch keys to encoder steps and clicks, with typematic auto repeat.
// ---------------------------------------------------------------------------
// Usage:
//   The in_ stream carries key events (in_tuser 0) and polls (in_tuser 1),
//   each stamped with a 48-bit microsecond time. Key events produce no beat
//   on the out_ stream; every poll produces exactly one beat with the step
//   count gathered since the previous poll and the encoder button state. The user writes
//   the four registers via the cfg_ port only while the stream is idle (unenforced).
// Pipeline and throughput:
//   One item per cycle while no poll is stalled. A beat is accepted into the input
//   register and processed from there; a poll's result goes to the output register,
//   which drives out_tvalid. The rate is set by the single pass of the
//   repeat lanes (one 48-bit add and compare per lane) between the input
//   register and the output register.
// Reset:
//   Synchronous, active low. Clears the stream registers, the repeat lanes,
//   the step count and the click queue, and loads the register defaults.
// Stall:
//   While out_tvalid waits on out_tready, key events still pass; a poll holds
//   in the input register and in_tready drops until the output frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module touch_key_repeat_encoder (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [tkre_pkg::IN_DATA_W-1:0]      in_tdata,  // key_number[1:0], key_down[2],
                                                              // time_us[50:3], zero pad
  input  wire logic                                in_tuser,  // op
  // Result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [tkre_pkg::OUT_DATA_W-1:0]          out_tdata, // step_count[15:0],
                                                              // button_pressed[16], zero pad
  // Configuration writes
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_addr,
  input  wire logic [tkre_pkg::DELAY_W-1:0]        cfg_wdata
);

  // Configuration registers
  logic                          rotated_270_r;
  logic [tkre_pkg::DELAY_W-1:0]  init_delay_r;
  logic [tkre_pkg::DELAY_W-1:0]  repeat_intvl_r;
  logic [tkre_pkg::CLICK_W-1:0]  max_clicks_r;

  // Input register
  logic                          in_valid_r;
  tkre_pkg::item_t               item_r;
  logic                          advance;

  // Output register
  logic                          out_valid_r;
  logic [tkre_pkg::OUT_DATA_W-1:0] out_data_r;

  // Working state
  logic signed [tkre_pkg::STEP_W-1:0] accum_r, accum_nxt;
  logic signed [tkre_pkg::STEP_W-1:0] acc_left, acc_both;
  tkre_pkg::lane_cmd_t           left_cmd, right_cmd;
  tkre_pkg::click_cmd_t          click_cmd;
  logic                          fire_left, fire_right;
  logic                          button;
  logic                          is_poll, is_key;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotated_270_r  <= 1'b0;
      init_delay_r   <= tkre_pkg::INIT_DELAY_RST;
      repeat_intvl_r <= tkre_pkg::REPEAT_INTVL_RST;
      max_clicks_r   <= tkre_pkg::MAX_CLICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tkre_pkg::REG_ROTATED_270:  rotated_270_r  <= cfg_wdata[0];
        tkre_pkg::REG_INIT_DELAY:   init_delay_r   <= cfg_wdata;
        tkre_pkg::REG_REPEAT_INTVL: repeat_intvl_r <= cfg_wdata;
        tkre_pkg::REG_MAX_CLICKS:   max_clicks_r   <= cfg_wdata[tkre_pkg::CLICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: key events always pass, a poll needs a free output slot
  assign is_poll   = in_valid_r && (item_r.op == tkre_pkg::OP_POLL);
  assign is_key    = in_valid_r && (item_r.op == tkre_pkg::OP_KEY);
  assign advance   = is_key || (is_poll && (!out_valid_r || out_tready));
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.op         <= in_tuser;
      item_r.key_number <= in_tdata[1:0];
      item_r.key_down   <= in_tdata[2];
      item_r.time_us    <= in_tdata[50:3];
    end
  end

  // Decode into lane and click commands
  always_comb begin
    left_cmd  = '{press: 1'b0, release_key: 1'b0, poll: 1'b0, now: item_r.time_us};
    right_cmd = '{press: 1'b0, release_key: 1'b0, poll: 1'b0, now: item_r.time_us};
    click_cmd = '{press: 1'b0, release_key: 1'b0, poll: 1'b0};
    if (advance) begin
      if (is_poll) begin
        left_cmd.poll  = 1'b1;
        right_cmd.poll = 1'b1;
        click_cmd.poll = 1'b1;
      end else begin
        unique case (item_r.key_number)
          tkre_pkg::KEY_LEFT: begin
            left_cmd.press       = item_r.key_down;
            left_cmd.release_key = !item_r.key_down;
          end
          tkre_pkg::KEY_SELECT: begin
            click_cmd.press       = item_r.key_down;
            click_cmd.release_key = !item_r.key_down;
          end
          tkre_pkg::KEY_RIGHT: begin
            right_cmd.press       = item_r.key_down;
            right_cmd.release_key = !item_r.key_down;
          end
          tkre_pkg::KEY_INVALID: ;
          default: ;
        endcase
      end
    end
  end

  tkre_repeat_lane u_left (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (left_cmd),
    .initial_delay_us   (init_delay_r),
    .repeat_interval_us (repeat_intvl_r),
    .fire               (fire_left)
  );

  tkre_repeat_lane u_right (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (right_cmd),
    .initial_delay_us   (init_delay_r),
    .repeat_interval_us (repeat_intvl_r),
    .fire               (fire_right)
  );

  tkre_click_queue u_click (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (click_cmd),
    .max_pending_clicks (max_clicks_r),
    .button_pressed     (button)
  );

  // Step count: left first, then right, each saturating on its own
  // (left steps down unless rotated; right is the opposite)
  assign acc_left = fire_left  ? tkre_pkg::sat_step(accum_r,  rotated_270_r)  : accum_r;
  assign acc_both = fire_right ? tkre_pkg::sat_step(acc_left, !rotated_270_r) : acc_left;

  always_comb begin
    accum_nxt = accum_r;
    if (advance) begin
      accum_nxt = is_poll ? '0 : acc_both;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else begin
      accum_r <= accum_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && is_poll) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_poll) begin
      out_data_r <= {{(tkre_pkg::OUT_DATA_W-tkre_pkg::STEP_W-1){1'b0}}, button, acc_both};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/tkre_repeat_lane.sv =====
// ---------------------------------------------------------------------------
// tkre_repeat_lane
// Auto-repeat timer of one direction key: first press and due repeats.
// ---------------------------------------------------------------------------
`default_nettype none

module tkre_repeat_lane (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tkre_pkg::lane_cmd_t               cmd,
  input  wire logic [tkre_pkg::DELAY_W-1:0]      initial_delay_us,
  input  wire logic [tkre_pkg::DELAY_W-1:0]      repeat_interval_us,
  output logic                                   fire
);

  logic                         active_r, active_nxt;
  logic [tkre_pkg::TIME_W-1:0]  next_time_r, next_time_nxt;
  logic [tkre_pkg::TIME_W-1:0]  deadline;
  logic                         due;

  // Deadline for a new press or for the next repeat, modulo 2^48
  assign deadline = cmd.now + {{(tkre_pkg::TIME_W-tkre_pkg::DELAY_W){1'b0}},
                               (cmd.press ? initial_delay_us : repeat_interval_us)};
  assign due      = active_r && (cmd.now >= next_time_r);

  // A step fires on a fresh press or on a poll that finds the repeat due
  always_comb begin
    fire          = 1'b0;
    active_nxt    = active_r;
    next_time_nxt = next_time_r;
    if (cmd.press) begin
      if (!active_r) begin
        fire          = 1'b1;
        active_nxt    = 1'b1;
        next_time_nxt = deadline;
      end
    end else if (cmd.release_key) begin
      active_nxt    = 1'b0;
      next_time_nxt = '0;
    end else if (cmd.poll && due) begin
      fire          = 1'b1;
      next_time_nxt = deadline;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  // Only read while active, so no reset
  always_ff @(posedge clk) begin
    next_time_r <= next_time_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/tkre_click_queue.sv =====
// ---------------------------------------------------------------------------
// tkre_click_queue
// Select click queue and press/release pulse played out over polls.
// ---------------------------------------------------------------------------
`default_nettype none

module tkre_click_queue (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tkre_pkg::click_cmd_t              cmd,
  input  wire logic [tkre_pkg::CLICK_W-1:0]      max_pending_clicks,
  output logic                                   button_pressed
);

  logic [tkre_pkg::CLICK_W-1:0] pending_r, pending_nxt;
  logic                         pulse_r, pulse_nxt;

  always_comb begin
    pending_nxt    = pending_r;
    pulse_nxt      = pulse_r;
    button_pressed = 1'b0;
    if (cmd.press) begin
      // queue one click up to the limit
      if (pending_r < max_pending_clicks) begin
        pending_nxt = pending_r + 2'd1;
      end
    end else if (cmd.release_key) begin
      // release trims the queue to one click
      if (pending_r > 2'd1) begin
        pending_nxt = 2'd1;
      end
    end else if (cmd.poll) begin
      if (pulse_r) begin
        pulse_nxt = 1'b0;
        if (pending_r != '0) begin
          pending_nxt = pending_r - 2'd1;
        end
      end else if (pending_r != '0) begin
        button_pressed = 1'b1;
        pulse_nxt      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      pulse_r   <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      pulse_r   <= pulse_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tkre_checker.sv =====
// ---------------------------------------------------------------------------
// tkre_checker
// Port-level checks of the touch key repeat encoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tkre_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tready,
  input  wire logic                                out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic [tkre_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic out_beat;
  logic last_btn_r;

  assign out_beat = out_tvalid && out_tready;

  // Button state of the last result beat taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_btn_r <= 1'b0;
    end else if (out_beat) begin
      last_btn_r <= out_tdata[tkre_pkg::STEP_W];
    end
  end

  // A stalled result holds its data
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Reset leaves no result pending
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)

  // A press pulse is always followed by a release before the next press
  `ASSERT_IMPLIES(a_click_pulse, clk, rst_n, out_beat && out_tdata[tkre_pkg::STEP_W], !last_btn_r)

  // With the output slot empty the input is never stalled
  `ASSERT_IMPLIES(a_in_ready, clk, rst_n, !out_tvalid, in_tready)

endmodule

bind touch_key_repeat_encoder tkre_checker u_tkre_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/sv/encoder_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_event_checker
// Watches the key/poll stream, the result stream and the register port of the
// touch key repeat encoder. Keeps its own copy of the repeat lanes, step count
// and click queue, predicts one report per poll and compares each result beat.
// ----------------------------------------------------------------------------

module encoder_event_checker
  import tkre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key_number[1:0], key_down[2], time_us[50:3]
  input  logic                  in_tuser,   // op
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // step_count[15:0], button_pressed[16]
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [DELAY_W-1:0]    cfg_wdata,
  output int                    fail_count,
  output int                    reports_waiting
);

  typedef struct packed {
    logic signed [STEP_W-1:0] step_count;
    logic                     button_pressed;
  } enc_report_t;

  // Mirror of the register file
  logic               rot_270;
  logic [DELAY_W-1:0] first_delay;
  logic [DELAY_W-1:0] repeat_gap;
  logic [CLICK_W-1:0] click_limit;

  // Mirror of the key state
  logic                     repeating  [3];
  logic [TIME_W-1:0]        repeat_due [3];
  logic signed [STEP_W-1:0] step_sum;
  logic                     click_shown;
  logic [CLICK_W-1:0]       clicks_queued;

  enc_report_t report_q [$];
  int          fails = 0;

  function automatic void note_failure(input string msg);
    fails++;
    if (fails <= 10) $display("mismatch: %s", msg);
  endfunction

  // One step of a left/right key, or one queued click for select
  function automatic void fire_key(input logic [KEY_W-1:0] key);
    logic up;
    if (key == KEY_SELECT) begin
      if (clicks_queued < click_limit) clicks_queued++;
    end else begin
      up = (key == KEY_RIGHT) ^ rot_270;
      if (up && step_sum != STEP_MAX) step_sum++;
      else if (!up && step_sum != STEP_MIN) step_sum--;
    end
  endfunction

  // Apply one accepted item; a poll queues the report it must produce
  function automatic void advance_keypad(input item_t it);
    enc_report_t rep;
    int          k;
    if (it.op == OP_KEY) begin
      if (it.key_number != KEY_INVALID) begin
        if (!it.key_down) begin
          repeating[it.key_number]  = 1'b0;
          repeat_due[it.key_number] = '0;
          if (it.key_number == KEY_SELECT && clicks_queued > 1) clicks_queued = 1;
        end else if (!repeating[it.key_number]) begin
          fire_key(it.key_number);
          if (it.key_number != KEY_SELECT) begin
            repeating[it.key_number]  = 1'b1;
            repeat_due[it.key_number] = it.time_us + TIME_W'(first_delay);
          end
        end
      end
    end else begin
      // at most one due repeat per key on each poll
      for (k = 0; k < 3; k++) begin
        if (repeating[k] && it.time_us >= repeat_due[k]) begin
          fire_key(k[KEY_W-1:0]);
          repeat_due[k] = it.time_us + TIME_W'(repeat_gap);
        end
      end
      rep.step_count = step_sum;
      step_sum = '0;
      // click plays as press on one poll, release on the next
      if (click_shown) begin
        rep.button_pressed = 1'b0;
        click_shown = 1'b0;
        if (clicks_queued > 0) clicks_queued--;
      end else if (clicks_queued > 0) begin
        rep.button_pressed = 1'b1;
        click_shown = 1'b1;
      end else begin
        rep.button_pressed = 1'b0;
      end
      report_q.push_back(rep);
    end
  endfunction

  always @(posedge clk) begin : watch
    enc_report_t got;
    enc_report_t want;
    int          k;
    if (!rst_n) begin
      rot_270       = 1'b0;
      first_delay   = INIT_DELAY_RST;
      repeat_gap    = REPEAT_INTVL_RST;
      click_limit   = MAX_CLICKS_RST;
      for (k = 0; k < 3; k++) begin
        repeating[k]  = 1'b0;
        repeat_due[k] = '0;
      end
      step_sum      = '0;
      click_shown   = 1'b0;
      clicks_queued = '0;
      report_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_ROTATED_270:  rot_270     = cfg_wdata[0];
          REG_INIT_DELAY:   first_delay = cfg_wdata;
          REG_REPEAT_INTVL: repeat_gap  = cfg_wdata;
          REG_MAX_CLICKS:   click_limit = cfg_wdata[CLICK_W-1:0];
          default: ;
        endcase
      end
      // result beat against the oldest report
      if (out_tvalid && out_tready) begin
        got.step_count     = out_tdata[STEP_W-1:0];
        got.button_pressed = out_tdata[STEP_W];
        if (report_q.size() == 0) begin
          note_failure($sformatf("result beat with no poll waiting: step %0d button %0b",
                                 got.step_count, got.button_pressed));
        end else begin
          want = report_q.pop_front();
          if (got.step_count !== want.step_count)
            note_failure($sformatf("step_count expected %0d got %0d",
                                   want.step_count, got.step_count));
          if (got.button_pressed !== want.button_pressed)
            note_failure($sformatf("button_pressed expected %0b got %0b",
                                   want.button_pressed, got.button_pressed));
        end
      end
      // accepted input beat
      if (in_tvalid && in_tready)
        advance_keypad({in_tuser, in_tdata[1:0], in_tdata[2], in_tdata[TIME_W+2:3]});
    end
    fail_count      <= fails;
    reports_waiting <= report_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the touch key repeat encoder: a directed pass over the corner
// cases, then random key/poll traffic under a series of register settings
// with random idling on both streams.
// ----------------------------------------------------------------------------

module tb;
  import tkre_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 120;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 140;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // key_number[1:0], key_down[2], time_us[50:3]
  logic                  in_tuser;   // op
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // step_count[15:0], button_pressed[16]
  logic                  cfg_we;
  logic [1:0]            cfg_addr;
  logic [DELAY_W-1:0]    cfg_wdata;
  int                    fail_count;
  int                    reports_waiting;

  logic              idle_en  = 1'b0;
  logic              hold_req = 1'b0;
  logic [TIME_W-1:0] t_now;
  logic              held [3];
  int unsigned       cycles = 0;

  touch_key_repeat_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  encoder_event_checker event_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .reports_waiting (reports_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_ready
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // One input beat, with an optional idle burst ahead of it
  task automatic send_event(input logic op, input logic [KEY_W-1:0] key, input logic dn,
                            input logic [TIME_W-1:0] t);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-TIME_W-3){1'b0}}, t, dn, key};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and let every report drain
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DELAY_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic rot, input logic [DELAY_W-1:0] dly,
                              input logic [DELAY_W-1:0] intv, input logic [CLICK_W-1:0] maxc);
    wait_quiet();
    write_reg(REG_ROTATED_270, {{(DELAY_W-1){1'b0}}, rot});
    write_reg(REG_INIT_DELAY, dly);
    write_reg(REG_REPEAT_INTVL, intv);
    write_reg(REG_MAX_CLICKS, {{(DELAY_W-CLICK_W){1'b0}}, maxc});
  endtask

  // Mostly press/release pairs and polls, with some junk and time jumps
  task automatic random_item(input int unsigned tstep);
    int unsigned      pick;
    logic [KEY_W-1:0] k;
    logic             dn;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) t_now = TIME_W'({$urandom(), $urandom()});
    else t_now = t_now + TIME_W'($urandom_range(0, tstep));
    if (pick < 40) begin
      send_event(OP_POLL, KEY_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), t_now);
    end else if (pick < 88) begin
      k  = KEY_W'($urandom_range(0, 2));
      dn = ($urandom_range(0, 9) == 0) ? held[k] : !held[k];
      held[k] = dn;
      send_event(OP_KEY, k, dn, t_now);
    end else begin
      k  = KEY_W'($urandom_range(0, 3));
      dn = 1'($urandom_range(0, 1));
      if (k != KEY_INVALID) held[k] = dn;
      send_event(OP_KEY, k, dn, t_now);
    end
  endtask

  initial begin : stimulus
    int                 ph;
    int                 n;
    int unsigned        tstep;
    logic               rot;
    logic [DELAY_W-1:0] dly;
    logic [DELAY_W-1:0] intv;
    logic [CLICK_W-1:0] maxc;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_KEY;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_ROTATED_270;
    cfg_wdata <= '0;
    held = '{default: 1'b0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: short delays so repeats land within a few microseconds
    idle_en = 1'b1;
    program_regs(1'b0, 24'd10, 24'd5, 2'd3);
    send_event(OP_POLL, KEY_LEFT, 1'b0, 48'd1000);
    send_event(OP_KEY, KEY_INVALID, 1'b1, 48'd1001);   // invalid key is ignored
    send_event(OP_KEY, KEY_INVALID, 1'b0, 48'd1002);
    send_event(OP_KEY, KEY_LEFT, 1'b1, 48'd1003);
    send_event(OP_KEY, KEY_LEFT, 1'b1, 48'd1004);      // already held: no step
    send_event(OP_KEY, KEY_RIGHT, 1'b1, 48'd1005);
    send_event(OP_POLL, KEY_LEFT, 1'b0, 48'd1013);     // first left repeat
    send_event(OP_POLL, KEY_LEFT, 1'b0, 48'd1015);     // first right repeat
    repeat (4) send_event(OP_KEY, KEY_SELECT, 1'b1, 48'd1016);  // queue hits limit
    send_event(OP_KEY, KEY_SELECT, 1'b0, 48'd1020);    // trims queue to one
    send_event(OP_POLL, KEY_LEFT, 1'b0, 48'd1021);
    send_event(OP_POLL, KEY_LEFT, 1'b0, 48'd1022);
    send_event(OP_KEY, KEY_LEFT, 1'b0, 48'd1023);
    send_event(OP_KEY, KEY_RIGHT, 1'b0, 48'd1024);
    send_event(OP_POLL, KEY_LEFT, 1'b0, 48'd1025);
    // deadline wraps past the top of the time range and fires early
    send_event(OP_KEY, KEY_RIGHT, 1'b1, 48'hFFFF_FFFF_FFFD);
    send_event(OP_POLL, KEY_INVALID, 1'b1, 48'hFFFF_FFFF_FFFE);
    send_event(OP_POLL, KEY_INVALID, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_event(OP_KEY, KEY_RIGHT, 1'b0, 48'd0);
    send_event(OP_POLL, KEY_LEFT, 1'b0, 48'd0);

    t_now = 48'd5000;

    // Random traffic under several register settings
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: {rot, dly, intv, maxc} = {1'b0, INIT_DELAY_RST, REPEAT_INTVL_RST, MAX_CLICKS_RST};
        1: {rot, dly, intv, maxc} = {1'b1, 24'd20, 24'd7, 2'd3};
        2: {rot, dly, intv, maxc} = {1'b0, 24'd0, 24'd0, 2'd1};
        3: {rot, dly, intv, maxc} = {1'b1, 24'hFFFFFF, 24'hFFFFFF, 2'd0};
        4: {rot, dly, intv, maxc} = {1'b0, 24'd3, 24'd1, 2'd2};
        5: {rot, dly, intv, maxc} = {1'b1, 24'd0, 24'hFFFFFF, 2'd3};
        6: {rot, dly, intv, maxc} = {1'b0, 24'hFFFFFF, 24'd0, 2'd1};
        default: begin
          rot  = 1'($urandom_range(0, 1));
          dly  = DELAY_W'($urandom_range(0, 60));
          intv = DELAY_W'($urandom_range(0, 30));
          maxc = CLICK_W'($urandom_range(0, 3));
        end
      endcase
      // no idling in the final phase
      if (ph == NUM_PHASES - 1) idle_en = 1'b0;
      else idle_en = (ph == 0) || ($urandom_range(0, 3) != 0);
      program_regs(rot, dly, intv, maxc);
      tstep = (dly >> 1) + (intv >> 1) + 3;
      // long result hold-off while polls keep coming, so the input backs up
      if (ph == 1) begin
        hold_req = 1'b1;
        repeat (30) begin
          t_now = t_now + TIME_W'($urandom_range(0, tstep));
          send_event(OP_POLL, KEY_LEFT, 1'b0, t_now);
        end
      end
      for (n = 0; n < PHASE_ITEMS; n++) random_item(tstep);
    end

    wait_quiet();
    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
